// ----- src/tfn_pkg.sv -----
// Package for the triangle face normal block: widths and pipeline constants.
// No dependencies; used by triangle_face_normal.
package tfn_pkg;

  // Vertex coordinate width (signed Q7.8 at 16 bits)
  localparam int CoordBits    = 16;
  // Fraction bits of each normal component (Q1.14 at 14)
  localparam int NormFracBits = 14;

  localparam int EdgeW   = CoordBits + 1;            // edge vector component
  localparam int ProdW   = 2 * EdgeW;                // edge product
  localparam int CrossW  = 2 * CoordBits + 3;        // cross product component
  localparam int MagW    = CrossW - 1;               // cross magnitude
  localparam int HalfW   = MagW / 2;                 // half of a magnitude
  localparam int SqW     = 2 * MagW;                 // squared magnitude
  localparam int LenW    = SqW + 2;                  // squared length
  localparam int RemW    = LenW + 2 * NormFracBits + 3; // square root remainder
  localparam int AccW    = LenW + NormFracBits + 2;  // quotient times length
  localparam int QW      = NormFracBits + 1;         // quotient magnitude
  localparam int OutW    = NormFracBits + 2;         // output component
  localparam int NumIter = NormFracBits + 1;         // one quotient bit per stage
  // Cycles from the accepting edge to the edge that takes the result
  localparam int Latency = NumIter + 7;

endpackage

// ----- src/triangle_face_normal.sv -----
// Triangle face normal. Throughput is one item per cycle; busy_o stays low, as the
// pipeline never stalls.
// Depth is set by the bit-per-stage quotient search (NormFracBits + 1 stages)
// behind six arithmetic stages: edges, products, cross, partial squares, squares, length.
// Reset clears all valid bits; data registers are not reset. Depends on tfn_pkg.
module triangle_face_normal (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  input  logic signed [tfn_pkg::CoordBits-1:0] a_x_i,
  input  logic signed [tfn_pkg::CoordBits-1:0] a_y_i,
  input  logic signed [tfn_pkg::CoordBits-1:0] a_z_i,
  input  logic signed [tfn_pkg::CoordBits-1:0] b_x_i,
  input  logic signed [tfn_pkg::CoordBits-1:0] b_y_i,
  input  logic signed [tfn_pkg::CoordBits-1:0] b_z_i,
  input  logic signed [tfn_pkg::CoordBits-1:0] c_x_i,
  input  logic signed [tfn_pkg::CoordBits-1:0] c_y_i,
  input  logic signed [tfn_pkg::CoordBits-1:0] c_z_i,
  output logic signed [tfn_pkg::OutW-1:0]      norm_x_o,
  output logic signed [tfn_pkg::OutW-1:0]      norm_y_o,
  output logic signed [tfn_pkg::OutW-1:0]      norm_z_o,
  output logic                                 degenerate_o
);

  localparam int NI = tfn_pkg::NumIter;
  localparam int F  = tfn_pkg::NormFracBits;

  // no backpressure anywhere
  assign busy_o = 1'b0;

  // ---------------- stage 1: edge vectors ----------------
  logic                             v1_q;
  logic signed [tfn_pkg::EdgeW-1:0] e0_q [3];
  logic signed [tfn_pkg::EdgeW-1:0] e1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q[0] <= tfn_pkg::EdgeW'(b_x_i) - tfn_pkg::EdgeW'(a_x_i);
    e0_q[1] <= tfn_pkg::EdgeW'(b_y_i) - tfn_pkg::EdgeW'(a_y_i);
    e0_q[2] <= tfn_pkg::EdgeW'(b_z_i) - tfn_pkg::EdgeW'(a_z_i);
    e1_q[0] <= tfn_pkg::EdgeW'(c_x_i) - tfn_pkg::EdgeW'(a_x_i);
    e1_q[1] <= tfn_pkg::EdgeW'(c_y_i) - tfn_pkg::EdgeW'(a_y_i);
    e1_q[2] <= tfn_pkg::EdgeW'(c_z_i) - tfn_pkg::EdgeW'(a_z_i);
  end

  // ---------------- stage 2: cross product terms ----------------
  logic                             v2_q;
  logic signed [tfn_pkg::ProdW-1:0] pp_q [3];
  logic signed [tfn_pkg::ProdW-1:0] pm_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q[0] <= e0_q[1] * e1_q[2];
    pm_q[0] <= e0_q[2] * e1_q[1];
    pp_q[1] <= e0_q[2] * e1_q[0];
    pm_q[1] <= e0_q[0] * e1_q[2];
    pp_q[2] <= e0_q[0] * e1_q[1];
    pm_q[2] <= e0_q[1] * e1_q[0];
  end

  // ---------------- stage 3: cross product ----------------
  logic                              v3_q;
  logic signed [tfn_pkg::CrossW-1:0] n_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      n_q[i] <= tfn_pkg::CrossW'(pp_q[i]) - tfn_pkg::CrossW'(pm_q[i]);
    end
  end

  // ---------------- stage 4: partial squares of magnitudes ----------------
  logic                               v4_q;
  logic                               deg4_q;
  logic [2:0]                         neg4_q;
  logic [2*tfn_pkg::HalfW-1:0]        hh_q [3];
  logic [2*tfn_pkg::HalfW-1:0]        hl_q [3];
  logic [2*tfn_pkg::HalfW-1:0]        ll_q [3];
  logic [tfn_pkg::CrossW-1:0]         abs_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_d[i] = n_q[i][tfn_pkg::CrossW-1] ? tfn_pkg::CrossW'(-n_q[i]) : n_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    deg4_q <= (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
    for (int i = 0; i < 3; i++) begin
      neg4_q[i] <= n_q[i][tfn_pkg::CrossW-1];
      hh_q[i] <= abs_d[i][tfn_pkg::MagW-1:tfn_pkg::HalfW] *
                 abs_d[i][tfn_pkg::MagW-1:tfn_pkg::HalfW];
      hl_q[i] <= abs_d[i][tfn_pkg::MagW-1:tfn_pkg::HalfW] *
                 abs_d[i][tfn_pkg::HalfW-1:0];
      ll_q[i] <= abs_d[i][tfn_pkg::HalfW-1:0] * abs_d[i][tfn_pkg::HalfW-1:0];
    end
  end

  // ---------------- stage 5: squared magnitudes ----------------
  logic                     v5_q;
  logic                     deg5_q;
  logic [2:0]               neg5_q;
  logic [tfn_pkg::SqW-1:0]  sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    deg5_q <= deg4_q;
    neg5_q <= neg4_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= (tfn_pkg::SqW'(hh_q[i]) << (2 * tfn_pkg::HalfW)) +
                 (tfn_pkg::SqW'(hl_q[i]) << (tfn_pkg::HalfW + 1)) +
                 tfn_pkg::SqW'(ll_q[i]);
    end
  end

  // ---------------- quotient search registers ----------------
  // stage s holds the state after quotient bits F .. F-s+1 are decided
  logic                     it_vld_q [NI+1];
  logic                     it_deg_q [NI+1];
  logic [2:0]               it_neg_q [NI+1];
  logic [tfn_pkg::LenW-1:0] it_len_q [NI+1];
  logic [tfn_pkg::RemW-1:0] it_rem_q [NI+1][3];
  logic [tfn_pkg::AccW-1:0] it_acc_q [NI+1][3];
  logic [tfn_pkg::QW-1:0]   it_quo_q [NI+1][3];

  // stage 6: squared length and initial remainders c^2 * 2^(2F)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_vld_q[0] <= 1'b0;
    end else begin
      it_vld_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it_deg_q[0] <= deg5_q;
    it_neg_q[0] <= neg5_q;
    it_len_q[0] <= tfn_pkg::LenW'(sq_q[0]) + tfn_pkg::LenW'(sq_q[1]) +
                   tfn_pkg::LenW'(sq_q[2]);
    for (int i = 0; i < 3; i++) begin
      it_rem_q[0][i] <= tfn_pkg::RemW'(sq_q[i]) << (2 * F);
      it_acc_q[0][i] <= '0;
      it_quo_q[0][i] <= '0;
    end
  end

  // one quotient bit per stage: trial (2*q*L + L*2^b) * 2^b against remainder
  for (genvar s = 1; s <= NI; s++) begin : g_iter
    localparam int B = F - s + 1;
    logic [tfn_pkg::RemW-1:0] trial_d [3];
    logic                     take_d  [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial_d[i] = ((tfn_pkg::RemW'(it_acc_q[s-1][i]) << 1) +
                      (tfn_pkg::RemW'(it_len_q[s-1]) << B)) << B;
        take_d[i]  = trial_d[i] <= it_rem_q[s-1][i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        it_vld_q[s] <= 1'b0;
      end else begin
        it_vld_q[s] <= it_vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      it_deg_q[s] <= it_deg_q[s-1];
      it_neg_q[s] <= it_neg_q[s-1];
      it_len_q[s] <= it_len_q[s-1];
      for (int i = 0; i < 3; i++) begin
        if (take_d[i]) begin
          it_rem_q[s][i] <= it_rem_q[s-1][i] - trial_d[i];
          it_acc_q[s][i] <= it_acc_q[s-1][i] + (tfn_pkg::AccW'(it_len_q[s-1]) << B);
          it_quo_q[s][i] <= it_quo_q[s-1][i] | (tfn_pkg::QW'(1) << B);
        end else begin
          it_rem_q[s][i] <= it_rem_q[s-1][i];
          it_acc_q[s][i] <= it_acc_q[s-1][i];
          it_quo_q[s][i] <= it_quo_q[s-1][i];
        end
      end
    end
  end

  // ---------------- output stage: sign and degenerate case ----------------
  logic                            done_q;
  logic                            deg_q;
  logic signed [tfn_pkg::OutW-1:0] norm_q [3];
  logic [tfn_pkg::OutW-1:0]        mag_d  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = tfn_pkg::OutW'(it_quo_q[NI][i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= it_vld_q[NI];
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= it_deg_q[NI];
    for (int i = 0; i < 3; i++) begin
      if (it_deg_q[NI]) begin
        norm_q[i] <= '0;
      end else if (it_neg_q[NI][i]) begin
        norm_q[i] <= -mag_d[i];
      end else begin
        norm_q[i] <= mag_d[i];
      end
    end
  end

  assign done_o       = done_q;
  assign degenerate_o = deg_q;
  assign norm_x_o     = norm_q[0];
  assign norm_y_o     = norm_q[1];
  assign norm_z_o     = norm_q[2];

  // ---------------- assertions ----------------
  localparam logic signed [tfn_pkg::OutW-1:0] OneQ = tfn_pkg::OutW'(1) << F;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, tfn_pkg::Latency))
    else $error("result without a matching accepted item");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !degenerate_o |->
      norm_x_o <= OneQ && norm_x_o >= -OneQ && norm_y_o <= OneQ &&
      norm_y_o >= -OneQ && norm_z_o <= OneQ && norm_z_o >= -OneQ)
    else $error("normal component out of range");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !degenerate_o |-> norm_x_o != '0 || norm_y_o != '0 || norm_z_o != '0)
    else $error("unit normal came out zero");

endmodule
